// ===== hw/rtl/esbp_pkg.sv =====
// ----------------------------------------------------------------------------
// esbp_pkg
// Shared types and constants for the exact-size buffer pool.
// ----------------------------------------------------------------------------
package esbp_pkg;

  localparam int SLOTS       = 16;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SIZE_W      = 32;
  localparam int SUM_W       = 40;
  localparam int CNT_W       = 5;
  localparam int HANDLE_W    = 4;
  localparam int CNT_MAX     = 31;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef struct packed {
    logic                action;
    logic [SIZE_W-1:0]   alloc_size;
    logic [HANDLE_W-1:0] release_handle;
  } in_item_t;

  typedef struct packed {
    logic                granted;
    logic [HANDLE_W-1:0] handle;
    logic                reused;
    logic [CNT_W-1:0]    populated_slots;
    logic [SUM_W-1:0]    bytes_total;
  } out_item_t;

  // classified request handed from the front end to the back end
  typedef struct packed {
    op_t                 op;
    logic [SIZE_W-1:0]   size;
    logic [HANDLE_W-1:0] rel_handle;
    logic [SLOT_W-1:0]   slot;
    logic                slot_ok;
  } cmd_t;

endpackage

// ===== hw/rtl/esbp_front.sv =====
// ----------------------------------------------------------------------------
// esbp_front
// Accepts requests, decodes them into commands and queues them for the
// back end.
// ----------------------------------------------------------------------------
module esbp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  esbp_pkg::in_item_t in_item,
  output logic              q_valid,
  input  logic              q_pop,
  output esbp_pkg::cmd_t    q_cmd
);
  import esbp_pkg::*;

  localparam int WIDE_W = HANDLE_W + SLOT_W;

  cmd_t                cmd;
  logic [WIDE_W-1:0]   rel_wide;
  cmd_t                mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push;
  logic                pop;

  // classify
  always_comb begin
    rel_wide       = WIDE_W'(in_item.release_handle);
    cmd.op         = in_item.action ? OP_RELEASE : OP_ALLOC;
    cmd.size       = in_item.alloc_size;
    cmd.rel_handle = in_item.release_handle;
    cmd.slot       = rel_wide[SLOT_W-1:0];
    cmd.slot_ok    = (rel_wide < WIDE_W'(SLOTS));
  end

  assign in_stall = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// ===== hw/rtl/esbp_back.sv =====
// ----------------------------------------------------------------------------
// esbp_back
// Slot table: size match and free-slot search, then commit of the slot
// update and the result register.
// ----------------------------------------------------------------------------
module esbp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  esbp_pkg::cmd_t     q_cmd,
  output logic               out_valid,
  input  logic               out_stall,
  output esbp_pkg::out_item_t out_item
);
  import esbp_pkg::*;

  localparam int HW_W = SLOT_W + HANDLE_W;

  logic [SLOTS-1:0]  pop_r, pop_nxt;
  logic [SLOTS-1:0]  busy_r, busy_nxt;
  logic [SIZE_W-1:0] size_r [SLOTS];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;

  logic              s1_v_r, s1_v_nxt;
  cmd_t              s1_cmd_r;
  logic [SLOTS-1:0]  hit_r;
  logic [SLOTS-1:0]  free_r;
  logic [SUM_W-1:0]  sum_sat_r;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              commit;
  logic              hit_any, free_any;
  logic [SLOT_W-1:0] hit_idx, free_idx;
  logic [SUM_W:0]    sum_wide;
  logic [HW_W-1:0]   handle_wide;
  logic              wr_size;

  assign q_pop     = q_valid && !s1_v_r;
  assign commit    = s1_v_r && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign sum_wide  = {1'b0, sum_r} + (SUM_W + 1)'(q_cmd.size);

  // lowest matching idle slot and lowest never-populated slot
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_r[i]) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (free_r[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    pop_nxt       = pop_r;
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    wr_size       = 1'b0;
    handle_wide   = '0;
    s1_v_nxt      = s1_v_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      s1_v_nxt = 1'b1;
    end

    if (commit) begin
      s1_v_nxt                 = 1'b0;
      out_valid_nxt            = 1'b1;
      out_item_nxt.granted     = 1'b1;
      out_item_nxt.reused      = 1'b0;
      out_item_nxt.handle      = '0;
      unique case (s1_cmd_r.op)
        OP_RELEASE: begin
          out_item_nxt.handle = s1_cmd_r.rel_handle;
          if (s1_cmd_r.slot_ok && pop_r[s1_cmd_r.slot]) begin
            busy_nxt[s1_cmd_r.slot] = 1'b0;
          end
        end
        OP_ALLOC: begin
          if (hit_any) begin
            busy_nxt[hit_idx]   = 1'b1;
            handle_wide         = HW_W'(hit_idx);
            out_item_nxt.handle = handle_wide[HANDLE_W-1:0];
            out_item_nxt.reused = 1'b1;
          end else if (free_any) begin
            pop_nxt[free_idx]   = 1'b1;
            busy_nxt[free_idx]  = 1'b1;
            wr_size             = 1'b1;
            handle_wide         = HW_W'(free_idx);
            out_item_nxt.handle = handle_wide[HANDLE_W-1:0];
            if (cnt_r < CNT_W'(CNT_MAX)) begin
              cnt_nxt = cnt_r + 1'b1;
            end
            sum_nxt = sum_sat_r;
          end else begin
            out_item_nxt.granted = 1'b0;
          end
        end
        default: begin
          out_item_nxt.granted = 1'b0;
        end
      endcase
      out_item_nxt.populated_slots = cnt_nxt;
      out_item_nxt.bytes_total     = sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_r       <= '0;
      busy_r      <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pop_r       <= pop_nxt;
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // search stage loads from the table, which holds still until the commit
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (q_pop) begin
      s1_cmd_r  <= q_cmd;
      sum_sat_r <= sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      for (int i = 0; i < SLOTS; i++) begin
        hit_r[i]  <= pop_r[i] && !busy_r[i] && (size_r[i] == q_cmd.size);
        free_r[i] <= !pop_r[i];
      end
    end
    if (wr_size) begin
      size_r[free_idx] <= s1_cmd_r.size;
    end
  end

endmodule

// ===== hw/rtl/exact_size_buffer_pool.sv =====
// ----------------------------------------------------------------------------
// exact_size_buffer_pool
// Buffer slot allocator with exact-size reuse of released slots.
// ----------------------------------------------------------------------------
// Usage:
//   in_item carries action (0 allocate, 1 release), alloc_size and
//   release_handle; a transaction takes place when in_valid is high and
//   in_stall is low. Every request gives exactly one result transaction on
//   out_item (granted, handle, reused, populated_slots, bytes_total), in
//   request order.
//   A request goes from the queue into the search registers and then, at
//   the commit, into the result register. The back end holds one request
//   at a time: it runs the size match and free-slot search, then the
//   commit, and takes the next request from the queue only after that
//   commit.
//   A two-entry queue after the decoder keeps taking requests while the
//   back end or the output register is busy.
//   While out_valid and out_stall are both high the result register holds
//   its contents; the back end then waits, the queue fills and in_stall
//   rises. Reset clears all slots, the populated count, the byte total,
//   the queue and the output valid; the block is ready the cycle after.
// ----------------------------------------------------------------------------
module exact_size_buffer_pool (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  esbp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output esbp_pkg::out_item_t out_item
);
  import esbp_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  esbp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd)
  );

  esbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the exact-size buffer pool. A directed run covers
// zero and all-ones sizes, busy-slot skipping, reuse, releases of unknown and
// idle slots and a full pool. A random run follows, mixing releases and
// allocations that mostly reuse known sizes. Both channels idle in random
// bursts. Each result is checked against an in-bench model of the slot table.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import esbp_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_TAIL   = 60;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  exact_size_buffer_pool dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #10 clk = ~clk;

  // model of the slot table
  logic              slot_used [SLOTS];
  logic              slot_taken[SLOTS];
  logic [SIZE_W-1:0] slot_bytes[SLOTS];
  logic [CNT_W-1:0]  used_count = '0;
  logic [SUM_W-1:0]  byte_total = '0;

  in_item_t          req_queue[$];
  out_item_t         grants_due[$];
  logic [SIZE_W-1:0] known_sizes[$];
  int                mismatches = 0;
  bit                quiet = 1'b0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i]  = 1'b0;
      slot_taken[i] = 1'b0;
      slot_bytes[i] = '0;
    end
  end

  function automatic out_item_t pool_grant(in_item_t req);
    out_item_t res;
    int        pick;
    res  = '0;
    pick = -1;
    if (op_t'(req.action) == OP_RELEASE) begin
      if (int'(req.release_handle) < SLOTS && slot_used[req.release_handle])
        slot_taken[req.release_handle] = 1'b0;
      res.granted = 1'b1;
      res.handle  = req.release_handle;
    end else begin
      for (int i = 0; i < SLOTS; i++)
        if (pick < 0 && slot_used[i] && !slot_taken[i] && slot_bytes[i] == req.alloc_size)
          pick = i;
      if (pick >= 0) begin
        slot_taken[pick] = 1'b1;
        res.granted = 1'b1;
        res.handle  = HANDLE_W'(pick);
        res.reused  = 1'b1;
      end else begin
        for (int i = 0; i < SLOTS; i++)
          if (pick < 0 && !slot_used[i])
            pick = i;
        if (pick >= 0) begin
          slot_used[pick]  = 1'b1;
          slot_taken[pick] = 1'b1;
          slot_bytes[pick] = req.alloc_size;
          if (used_count < CNT_W'(CNT_MAX))
            used_count = used_count + 1'b1;
          // total saturates rather than wrapping
          if (({SUM_W{1'b1}} - byte_total) < SUM_W'(req.alloc_size))
            byte_total = {SUM_W{1'b1}};
          else
            byte_total = byte_total + SUM_W'(req.alloc_size);
          res.granted = 1'b1;
          res.handle  = HANDLE_W'(pick);
        end
      end
    end
    res.populated_slots = used_count;
    res.bytes_total     = byte_total;
    return res;
  endfunction

  task automatic push_req(op_t op, logic [SIZE_W-1:0] size, logic [HANDLE_W-1:0] slot);
    in_item_t req;
    req.action         = op;
    req.alloc_size     = size;
    req.release_handle = slot;
    req_queue.push_back(req);
  endtask

  task automatic check_field(string field, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  // driver
  int send_gap  = 0;
  int send_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        grants_due.push_back(pool_grant(in_item));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (req_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet && send_calm == 0 && $urandom_range(0, 6) == 0) begin
          // idle burst, then a stretch without gaps
          in_valid  <= 1'b0;
          send_gap  = $urandom_range(0, 13);
          send_calm = $urandom_range(0, 30);
        end else begin
          in_item  <= req_queue.pop_front();
          in_valid <= 1'b1;
          if (send_calm > 0)
            send_calm--;
        end
      end
    end
  end

  // monitor
  int recv_gap  = 0;
  int recv_calm = 0;

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (grants_due.size() == 0) begin
          $error("result transaction with no request outstanding");
          mismatches++;
        end else begin
          want = grants_due.pop_front();
          check_field("granted", SUM_W'(want.granted), SUM_W'(out_item.granted));
          check_field("handle", SUM_W'(want.handle), SUM_W'(out_item.handle));
          check_field("reused", SUM_W'(want.reused), SUM_W'(out_item.reused));
          check_field("populated_slots", SUM_W'(want.populated_slots),
                      SUM_W'(out_item.populated_slots));
          check_field("bytes_total", want.bytes_total, out_item.bytes_total);
        end
      end
      if (recv_gap > 0) begin
        out_stall <= 1'b1;
        recv_gap--;
      end else if (!quiet && recv_calm == 0 && $urandom_range(0, 8) == 0) begin
        out_stall <= 1'b1;
        recv_gap  = $urandom_range(0, 13);
        recv_calm = $urandom_range(0, 40);
      end else begin
        out_stall <= 1'b0;
        if (recv_calm > 0)
          recv_calm--;
      end
    end
  end

  initial begin
    logic [SIZE_W-1:0] fill_sizes[13];
    in_item_t          req;
    int                roll;
    fill_sizes = '{32'd1, 32'd1, 32'd2, 32'd2, 32'd2, 32'h8000_0000, 32'h5555_5555,
                   32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678,
                   32'd3, 32'd3};

    push_req(OP_ALLOC, 32'd0, 4'd0);
    push_req(OP_ALLOC, 32'hFFFF_FFFF, 4'hF);
    push_req(OP_ALLOC, 32'hFFFF_FFFF, 4'd0);
    push_req(OP_RELEASE, 32'hFFFF_FFFF, 4'd1);
    push_req(OP_ALLOC, 32'hFFFF_FFFF, 4'd0);
    // slot 15 never populated yet
    push_req(OP_RELEASE, 32'd0, 4'd15);
    push_req(OP_RELEASE, 32'd0, 4'd2);
    // release of an already idle slot
    push_req(OP_RELEASE, 32'd0, 4'd2);
    push_req(OP_ALLOC, 32'hFFFF_FFFF, 4'd0);
    push_req(OP_RELEASE, 32'd0, 4'd1);
    foreach (fill_sizes[i])
      push_req(OP_ALLOC, fill_sizes[i], 4'(i));
    // pool full, no matching idle slot
    push_req(OP_ALLOC, 32'h0BAD_F00D, 4'd0);
    push_req(OP_ALLOC, 32'hFFFF_FFFF, 4'd0);

    known_sizes.push_back(32'd0);
    known_sizes.push_back(32'hFFFF_FFFF);
    foreach (fill_sizes[i])
      known_sizes.push_back(fill_sizes[i]);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // hold the sender until the directed results have drained
    @(posedge clk);
    while (req_queue.size() != 0 || in_valid || grants_due.size() != 0)
      @(posedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll               = $urandom_range(0, 99);
      req.alloc_size     = $urandom;
      req.release_handle = HANDLE_W'($urandom_range(0, 15));
      if (roll < 45) begin
        req.action = OP_RELEASE;
      end else begin
        req.action = OP_ALLOC;
        if (roll < 92)
          req.alloc_size = known_sizes[$urandom_range(0, known_sizes.size() - 1)];
      end
      req_queue.push_back(req);
    end

    while (req_queue.size() > QUIET_TAIL)
      @(posedge clk);
    quiet = 1'b1;

    while (req_queue.size() != 0 || in_valid || grants_due.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && grants_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
